// File: rtl/sstq_pkg.sv
// sstq_pkg: shared types and operation codes of the sorted timer queue.
// Used by the front queue, the executor, the top level and the testbench.
`default_nettype none
package sstq_pkg;

	localparam logic [2:0] OP_REGISTER = 3'd0;
	localparam logic [2:0] OP_SET      = 3'd1;
	localparam logic [2:0] OP_CLEAR    = 3'd2;
	localparam logic [2:0] OP_EXPIRE   = 3'd3;
	localparam logic [2:0] OP_SERVICE  = 3'd4;

	localparam logic ITEM_STATUS = 1'b0;
	localparam logic ITEM_FIRED  = 1'b1;

	typedef struct packed {
		logic [2:0]  operation;
		logic [3:0]  target_id;
		logic [31:0] time_value;
		logic        relative;
		logic        timer_kind;
		logic [31:0] now;
	} req_t;

	typedef struct packed {
		logic valid;
		req_t req;
	} req_head_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_FIND,
		ST_REMOVE,
		ST_PLACE,
		ST_INS_SCAN,
		ST_INSERT,
		ST_EXPIRE,
		ST_SERVICE,
		ST_EMIT
	} state_t;

endpackage
`default_nettype wire

// File: rtl/sstq_req_if.sv
// sstq_req_if: request channel of the timer queue, valid/ready with payload.
// Stands alone; no package needed.
`default_nettype none
interface sstq_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [3:0]  target_id;
	logic [31:0] time_value;
	logic        relative;
	logic        timer_kind;
	logic [31:0] now;

	modport source (output valid, operation, target_id, time_value, relative, timer_kind,
		now, input ready);
	modport sink (input valid, operation, target_id, time_value, relative, timer_kind,
		now, output ready);
endinterface
`default_nettype wire

// File: rtl/sstq_rsp_if.sv
// sstq_rsp_if: result channel of the timer queue, valid/ready with payload.
// Stands alone; no package needed.
`default_nettype none
interface sstq_rsp_if;
	logic        valid;
	logic        ready;
	logic        item_kind;
	logic        ok;
	logic [3:0]  result_id;
	logic [31:0] compare_time;
	logic        compare_armed;
	logic        deferred_pending;
	logic        last;

	modport source (output valid, item_kind, ok, result_id, compare_time, compare_armed,
		deferred_pending, last, input ready);
	modport sink (input valid, item_kind, ok, result_id, compare_time, compare_armed,
		deferred_pending, last, output ready);
endinterface
`default_nettype wire

// File: rtl/sstq_front.sv
// sstq_front: two-entry request queue between the input channel and the executor.
// Depends on sstq_pkg and sstq_req_if.
`default_nettype none
module sstq_front
	import sstq_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	sstq_req_if.sink   req,
	output req_head_t  head,
	input  wire logic  pop
);
	req_t       buf_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       take;

	assign req.ready = (cnt_q != 2'd2);
	assign push = req.valid && req.ready;
	assign take = pop && (cnt_q != 2'd0);
	assign head.valid = (cnt_q != 2'd0);
	assign head.req = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= '{operation: req.operation, target_id: req.target_id,
				time_value: req.time_value, relative: req.relative,
				timer_kind: req.timer_kind, now: req.now};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (take)
				rd_q <= ~rd_q;
			case ({push, take})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: rtl/sstq_back.sv
// sstq_back: executor that walks the ordered timer queue one entry a cycle
// and delivers fired timers and the status through an output register.
// Depends on sstq_pkg and sstq_rsp_if.
`default_nettype none
module sstq_back
	import sstq_pkg::*;
#(
	parameter int MAX_TIMERS_P = 16,
	parameter int TIME_WIDTH   = 32
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  req_head_t  head,
	output logic       pop,
	sstq_rsp_if.source rsp
);
	localparam int IW = (MAX_TIMERS_P > 1) ? $clog2(MAX_TIMERS_P) : 1;
	localparam int CW = $clog2(MAX_TIMERS_P + 1);
	localparam int SECOND = (MAX_TIMERS_P > 1) ? 1 : 0;

	function automatic logic earlier(input logic [TIME_WIDTH-1:0] a,
		input logic [TIME_WIDTH-1:0] b);
		logic [TIME_WIDTH-1:0] d;
		d = a - b;
		return d[TIME_WIDTH-1];
	endfunction

	logic [TIME_WIDTH-1:0] mt_q     [MAX_TIMERS_P];
	logic                  kind_q   [MAX_TIMERS_P];
	logic                  queued_q [MAX_TIMERS_P];
	logic                  shot_q   [MAX_TIMERS_P];
	logic [IW-1:0]         ol_q     [MAX_TIMERS_P];
	logic [IW-1:0]         fire_q   [MAX_TIMERS_P];
	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         nfree_q;
	logic [TIME_WIDTH-1:0] cmp_q;
	logic                  pend_q;
	logic [CW-1:0]         pos_q;
	logic [CW-1:0]         nfire_q;
	logic [CW-1:0]         eidx_q;
	logic                  ok_q;
	logic [3:0]            rid_q;
	logic [TIME_WIDTH-1:0] m_q;
	req_t                  req_q;
	state_t                state_q;
	state_t                state_d;

	logic                  ov_q;
	logic                  okind_q;
	logic                  ook_q;
	logic [3:0]            oid_q;
	logic                  olast_q;
	logic [TIME_WIDTH-1:0] ocmp_q;
	logic                  oarm_q;
	logic                  opend_q;

	logic [IW-1:0]         pos_ix;
	logic [IW-1:0]         cur_t;
	logic [IW-1:0]         idx;
	logic [TIME_WIDTH-1:0] now_t;
	logic [TIME_WIDTH-1:0] tv_t;
	logic [TIME_WIDTH-1:0] m_new;
	logic                  id_valid;
	logic                  set_good;
	logic                  in_range;
	logic                  due;
	logic                  slot_free;

	logic                  rm_en;
	logic                  push_en;
	logic                  emit_en;
	logic                  emit_fire;

	assign pos_ix   = pos_q[IW-1:0];
	assign cur_t    = ol_q[pos_ix];
	assign idx      = IW'(req_q.target_id);
	assign now_t    = TIME_WIDTH'(req_q.now);
	assign tv_t     = TIME_WIDTH'(req_q.time_value);
	assign m_new    = req_q.relative ? (now_t + tv_t) : tv_t;
	assign id_valid = (32'(req_q.target_id) < 32'(MAX_TIMERS_P)) &&
		(32'(req_q.target_id) < 32'(nfree_q));
	assign set_good = !(req_q.relative && earlier(m_new, mt_q[idx]));
	assign in_range = (pos_q < cnt_q);
	assign due      = !earlier(now_t, mt_q[cur_t]);
	assign slot_free = !ov_q || rsp.ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (head.valid)
					state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				case (req_q.operation)
					OP_SET: begin
						if (id_valid && set_good)
							state_d = queued_q[idx] ? ST_FIND : ST_PLACE;
						else
							state_d = ST_EMIT;
					end
					OP_CLEAR:   state_d = (id_valid && queued_q[idx]) ? ST_FIND : ST_EMIT;
					OP_EXPIRE:  state_d = ST_EXPIRE;
					OP_SERVICE: state_d = ST_SERVICE;
					default:    state_d = ST_EMIT;
				endcase
			end
			ST_FIND: begin
				if (cur_t == idx)
					state_d = ST_REMOVE;
			end
			ST_REMOVE:   state_d = (req_q.operation == OP_SET) ? ST_PLACE : ST_EMIT;
			ST_PLACE:    state_d = earlier(now_t, m_q) ? ST_INS_SCAN : ST_EMIT;
			ST_INS_SCAN: begin
				if (!(in_range && !earlier(m_q, mt_q[cur_t])))
					state_d = ST_INSERT;
			end
			ST_INSERT:   state_d = ST_EMIT;
			ST_EXPIRE: begin
				if (!in_range || shot_q[cur_t] || !due)
					state_d = ST_EMIT;
			end
			ST_SERVICE: begin
				if (!in_range)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free && !(eidx_q < nfire_q))
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop     = 1'b0;
		rm_en   = 1'b0;
		push_en = 1'b0;
		emit_en = 1'b0;
		case (state_q)
			ST_IDLE:    pop = head.valid;
			ST_REMOVE:  rm_en = 1'b1;
			ST_PLACE:   push_en = !earlier(now_t, m_q);
			ST_EXPIRE: begin
				if (in_range && !shot_q[cur_t] && due && !kind_q[cur_t]) begin
					rm_en   = 1'b1;
					push_en = 1'b1;
				end
			end
			ST_SERVICE: begin
				if (in_range && kind_q[cur_t] && shot_q[cur_t]) begin
					rm_en   = 1'b1;
					push_en = 1'b1;
				end
			end
			ST_EMIT:    emit_en = 1'b1;
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	assign emit_fire = emit_en && slot_free;

	always_ff @(posedge clk) begin
		if (pop)
			req_q <= head.req;
		if (state_q == ST_DISPATCH && req_q.operation == OP_REGISTER &&
				32'(nfree_q) < 32'(MAX_TIMERS_P)) begin
			mt_q[nfree_q[IW-1:0]]   <= '0;
			kind_q[nfree_q[IW-1:0]] <= req_q.timer_kind;
		end
		if (state_q == ST_DISPATCH && req_q.operation == OP_SET && id_valid && set_good) begin
			mt_q[idx] <= m_new;
			m_q       <= m_new;
		end
		if (push_en)
			fire_q[nfire_q[IW-1:0]] <= (state_q == ST_PLACE) ? idx : cur_t;
		if (rm_en) begin
			for (int i = 0; i < MAX_TIMERS_P - 1; i++) begin
				if (i >= 32'(pos_q))
					ol_q[i] <= ol_q[i+1];
			end
		end
		if (state_q == ST_INSERT) begin
			for (int i = 1; i < MAX_TIMERS_P; i++) begin
				if (i > 32'(pos_q))
					ol_q[i] <= ol_q[i-1];
			end
			ol_q[pos_ix] <= idx;
		end
		if (emit_fire) begin
			ocmp_q  <= cmp_q;
			oarm_q  <= (cnt_q != '0);
			opend_q <= pend_q;
			if (eidx_q < nfire_q) begin
				okind_q <= ITEM_FIRED;
				ook_q   <= 1'b1;
				oid_q   <= 4'(fire_q[eidx_q[IW-1:0]]);
				olast_q <= 1'b0;
			end else begin
				okind_q <= ITEM_STATUS;
				ook_q   <= ok_q;
				oid_q   <= rid_q;
				olast_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			nfree_q <= '0;
			cmp_q   <= '0;
			pend_q  <= 1'b0;
			pos_q   <= '0;
			nfire_q <= '0;
			eidx_q  <= '0;
			ok_q    <= 1'b0;
			rid_q   <= '0;
			ov_q    <= 1'b0;
			for (int i = 0; i < MAX_TIMERS_P; i++) begin
				queued_q[i] <= 1'b0;
				shot_q[i]   <= 1'b0;
			end
		end else begin
			state_q <= state_d;
			if (pop) begin
				ok_q    <= 1'b0;
				rid_q   <= '0;
				nfire_q <= '0;
				eidx_q  <= '0;
				pos_q   <= '0;
			end
			if (state_q == ST_DISPATCH) begin
				pos_q <= '0;
				case (req_q.operation)
					OP_REGISTER: begin
						if (32'(nfree_q) < 32'(MAX_TIMERS_P)) begin
							queued_q[nfree_q[IW-1:0]] <= 1'b0;
							shot_q[nfree_q[IW-1:0]]   <= 1'b0;
							ok_q    <= 1'b1;
							rid_q   <= 4'(nfree_q);
							nfree_q <= nfree_q + CW'(1);
						end
					end
					OP_SET: begin
						rid_q <= req_q.target_id;
						if (id_valid && set_good) begin
							shot_q[idx] <= 1'b0;
							ok_q        <= 1'b1;
						end
					end
					OP_CLEAR: begin
						rid_q <= req_q.target_id;
						if (id_valid && queued_q[idx])
							ok_q <= 1'b1;
					end
					OP_EXPIRE:  ok_q <= 1'b1;
					OP_SERVICE: begin
						ok_q   <= 1'b1;
						pend_q <= 1'b0;
					end
					default: ok_q <= 1'b0;
				endcase
			end
			if (state_q == ST_FIND && cur_t != idx)
				pos_q <= pos_q + CW'(1);
			if (state_q == ST_PLACE)
				pos_q <= '0;
			if (state_q == ST_INS_SCAN && in_range && !earlier(m_q, mt_q[cur_t]))
				pos_q <= pos_q + CW'(1);
			if (state_q == ST_INSERT) begin
				cnt_q         <= cnt_q + CW'(1);
				queued_q[idx] <= 1'b1;
				if (pos_q == '0)
					cmp_q <= m_q;
			end
			if (state_q == ST_EXPIRE && in_range && !shot_q[cur_t] && due) begin
				if (kind_q[cur_t]) begin
					shot_q[cur_t] <= 1'b1;
					pend_q        <= 1'b1;
					pos_q         <= pos_q + CW'(1);
				end else begin
					shot_q[cur_t] <= 1'b0;
					pos_q         <= '0;
				end
			end
			if (state_q == ST_SERVICE) begin
				if (in_range) begin
					if (kind_q[cur_t] && shot_q[cur_t])
						shot_q[cur_t] <= 1'b0;
					else
						pos_q <= pos_q + CW'(1);
				end else if (cnt_q != '0) begin
					cmp_q <= mt_q[ol_q[0]];
				end
			end
			if (rm_en) begin
				queued_q[cur_t] <= 1'b0;
				cnt_q           <= cnt_q - CW'(1);
				if (pos_q == '0 && cnt_q > CW'(1))
					cmp_q <= mt_q[ol_q[SECOND]];
			end
			if (push_en)
				nfire_q <= nfire_q + CW'(1);
			if (emit_fire && eidx_q < nfire_q)
				eidx_q <= eidx_q + CW'(1);
			if (emit_fire)
				ov_q <= 1'b1;
			else if (rsp.ready)
				ov_q <= 1'b0;
		end
	end

	assign rsp.valid            = ov_q;
	assign rsp.item_kind        = okind_q;
	assign rsp.ok               = ook_q;
	assign rsp.result_id        = oid_q;
	assign rsp.last             = olast_q;
	assign rsp.compare_time     = 32'(ocmp_q);
	assign rsp.compare_armed    = oarm_q;
	assign rsp.deferred_pending = opend_q;
endmodule
`default_nettype wire

// File: rtl/sorted_software_timer_queue_unit.sv
// sorted_software_timer_queue_unit: top level of the sorted timer queue.
// Depends on sstq_pkg, sstq_req_if, sstq_rsp_if, sstq_front and sstq_back.
//
// Requests enter a two-entry queue and are carried out one at a time by an
// executor that keeps the armed timers in an order list sorted by match time.
// Clear and set walk the order list one entry a cycle to find a queued timer,
// and set then walks it again to find the insertion point of a timer that is
// not yet due. Expire and service walk the list from the head, one entry per
// cycle; expire restarts from the head after each fired immediate timer.
// Each fired timer and then the final status leave through the output
// register, which holds while the receiver is not ready. Every result of one
// request carries the compare value, the armed flag and the pending flag as they stand after that request.
`default_nettype none
module sorted_software_timer_queue_unit
	import sstq_pkg::*;
#(
	parameter int MAX_TIMERS_P = 16,
	parameter int TIME_WIDTH   = 32
) (
	input wire logic   clk,
	input wire logic   arst_n,
	sstq_req_if.sink   req,
	sstq_rsp_if.source rsp
);
	req_head_t head;
	logic      pop;

	sstq_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.head   (head),
		.pop    (pop)
	);

	sstq_back #(
		.MAX_TIMERS_P (MAX_TIMERS_P),
		.TIME_WIDTH   (TIME_WIDTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.rsp    (rsp)
	);

	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.last != rsp.item_kind))
		else $error("last flag does not match status beat");

	a_fired_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.item_kind == ITEM_FIRED) |-> rsp.ok)
		else $error("fired beat without ok");

	a_status_after_fired: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.ready && rsp.item_kind == ITEM_FIRED) |=> rsp.valid)
		else $error("fired beat not followed by a further beat");
endmodule
`default_nettype wire

// File: tb/sorted_software_timer_queue_unit_tb.sv
// Testbench of sorted_software_timer_queue_unit: drives timer requests and
// checks every fired and status beat against an in-bench timer-queue predictor.
// Depends on sstq_pkg, sstq_req_if, sstq_rsp_if and the unit itself.
`timescale 1ns / 1ps
module sorted_software_timer_queue_unit_tb;
	import sstq_pkg::*;

	localparam int NTIMERS = 16;

	typedef struct packed {
		logic        item_kind;
		logic        ok;
		logic [3:0]  result_id;
		logic [31:0] compare_time;
		logic        compare_armed;
		logic        deferred_pending;
		logic        last;
	} beat_t;

	logic clk;
	logic arst_n;

	sstq_req_if req_ch ();
	sstq_rsp_if rsp_ch ();

	sorted_software_timer_queue_unit #(.MAX_TIMERS_P(NTIMERS), .TIME_WIDTH(32)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	req_t  pending_reqs[$];
	beat_t due_beats[$];
	int    send_idle_pct;
	int    recv_idle_pct;
	int    errors;
	logic  req_fire;

	// timer state mirror
	logic [31:0] tmr_match[NTIMERS];
	logic        tmr_kind[NTIMERS];
	logic        tmr_queued[NTIMERS];
	logic        tmr_shot[NTIMERS];
	logic [3:0]  arm_order[NTIMERS];
	int          arm_count;
	int          next_id;
	logic [31:0] cmp_val;
	logic        defer_flag;

	function automatic bit precedes(logic [31:0] a, logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d[31];
	endfunction

	function automatic void unarm_at(int p);
		if (p >= arm_count)
			return;
		tmr_queued[arm_order[p]] = 1'b0;
		for (int i = p; i + 1 < arm_count; i++)
			arm_order[i] = arm_order[i + 1];
		arm_count--;
		if (p == 0 && arm_count > 0)
			cmp_val = tmr_match[arm_order[0]];
	endfunction

	function automatic int slot_of(int id);
		for (int i = 0; i < arm_count; i++)
			if (arm_order[i] == id)
				return i;
		return arm_count;
	endfunction

	function automatic void arm_sorted(int id);
		int p;
		p = 0;
		if (arm_count >= NTIMERS)
			return;
		while (p < arm_count && !precedes(tmr_match[id], tmr_match[arm_order[p]]))
			p++;
		for (int i = arm_count; i > p; i--)
			arm_order[i] = arm_order[i - 1];
		arm_order[p] = id[3:0];
		arm_count++;
		tmr_queued[id] = 1'b1;
		if (p == 0)
			cmp_val = tmr_match[id];
	endfunction

	function automatic void predict_beats(req_t r);
		int fired[$];
		logic ok;
		logic [3:0] rid;
		logic [31:0] m;
		int i;
		int t;
		beat_t b;
		ok = 1'b0;
		rid = '0;
		case (r.operation)
			OP_REGISTER: begin
				if (next_id < NTIMERS) begin
					tmr_match[next_id] = '0;
					tmr_kind[next_id] = r.timer_kind;
					tmr_queued[next_id] = 1'b0;
					tmr_shot[next_id] = 1'b0;
					ok = 1'b1;
					rid = next_id[3:0];
					next_id++;
				end
			end
			OP_SET: begin
				rid = r.target_id;
				if (r.target_id < next_id) begin
					m = r.relative ? r.now + r.time_value : r.time_value;
					if (!(r.relative && precedes(m, tmr_match[r.target_id]))) begin
						tmr_match[r.target_id] = m;
						if (tmr_queued[r.target_id])
							unarm_at(slot_of(r.target_id));
						tmr_shot[r.target_id] = 1'b0;
						if (!precedes(r.now, m))
							fired.push_back(r.target_id);
						else
							arm_sorted(r.target_id);
						ok = 1'b1;
					end
				end
			end
			OP_CLEAR: begin
				rid = r.target_id;
				if (r.target_id < next_id && tmr_queued[r.target_id]) begin
					unarm_at(slot_of(r.target_id));
					ok = 1'b1;
				end
			end
			OP_EXPIRE: begin
				i = 0;
				while (i < arm_count) begin
					t = arm_order[i];
					if (tmr_shot[t] || precedes(r.now, tmr_match[t]))
						break;
					if (tmr_kind[t] == 1'b0) begin
						unarm_at(i);
						tmr_shot[t] = 1'b0;
						fired.push_back(t);
						i = 0;
					end else begin
						tmr_shot[t] = 1'b1;
						defer_flag = 1'b1;
						i++;
					end
				end
				ok = 1'b1;
			end
			OP_SERVICE: begin
				i = 0;
				defer_flag = 1'b0;
				while (i < arm_count) begin
					t = arm_order[i];
					if (tmr_kind[t] && tmr_shot[t]) begin
						unarm_at(i);
						tmr_shot[t] = 1'b0;
						fired.push_back(t);
					end else begin
						i++;
					end
				end
				if (arm_count > 0)
					cmp_val = tmr_match[arm_order[0]];
				ok = 1'b1;
			end
			default: ;
		endcase
		b.compare_time = cmp_val;
		b.compare_armed = arm_count > 0;
		b.deferred_pending = defer_flag;
		foreach (fired[k]) begin
			b.item_kind = ITEM_FIRED;
			b.ok = 1'b1;
			b.result_id = fired[k][3:0];
			b.last = 1'b0;
			due_beats.push_back(b);
		end
		b.item_kind = ITEM_STATUS;
		b.ok = ok;
		b.result_id = rid;
		b.last = 1'b1;
		due_beats.push_back(b);
	endfunction

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	// driver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= $urandom_range(99) >= recv_idle_pct;
			if (!req_ch.valid || req_fire) begin
				if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					req_t r;
					r = pending_reqs.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.operation <= r.operation;
					req_ch.target_id <= r.target_id;
					req_ch.time_value <= r.time_value;
					req_ch.relative <= r.relative;
					req_ch.timer_kind <= r.timer_kind;
					req_ch.now <= r.now;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		req_fire <= req_ch.valid && req_ch.ready;
		if (arst_n && req_ch.valid && req_ch.ready) begin
			req_t r;
			r.operation = req_ch.operation;
			r.target_id = req_ch.target_id;
			r.time_value = req_ch.time_value;
			r.relative = req_ch.relative;
			r.timer_kind = req_ch.timer_kind;
			r.now = req_ch.now;
			predict_beats(r);
		end
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			beat_t got;
			beat_t want;
			got.item_kind = rsp_ch.item_kind;
			got.ok = rsp_ch.ok;
			got.result_id = rsp_ch.result_id;
			got.compare_time = rsp_ch.compare_time;
			got.compare_armed = rsp_ch.compare_armed;
			got.deferred_pending = rsp_ch.deferred_pending;
			got.last = rsp_ch.last;
			if (due_beats.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat %h", $time, got);
			end else begin
				want = due_beats.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t: beat mismatch exp kind=%b ok=%b id=%0d cmp=%h arm=%b pend=%b last=%b",
						$time, want.item_kind, want.ok, want.result_id, want.compare_time,
						want.compare_armed, want.deferred_pending, want.last);
					$display("%0t:                act kind=%b ok=%b id=%0d cmp=%h arm=%b pend=%b last=%b",
						$time, got.item_kind, got.ok, got.result_id, got.compare_time,
						got.compare_armed, got.deferred_pending, got.last);
				end
			end
		end
	end

	logic [31:0] clock_now;

	function automatic void add_req(logic [2:0] op, logic [3:0] id, logic [31:0] tv,
		logic rel, logic kind, logic [31:0] nw);
		req_t r;
		r.operation = op;
		r.target_id = id;
		r.time_value = tv;
		r.relative = rel;
		r.timer_kind = kind;
		r.now = nw;
		pending_reqs.push_back(r);
	endfunction

	function automatic void add_random_req();
		int pick;
		logic [2:0] op;
		logic [31:0] tv;
		logic rel;
		pick = $urandom_range(99);
		clock_now = clock_now + $urandom_range(60);
		if (pick < 45)
			op = OP_SET;
		else if (pick < 70)
			op = OP_EXPIRE;
		else if (pick < 82)
			op = OP_SERVICE;
		else if (pick < 95)
			op = OP_CLEAR;
		else if (pick < 98)
			op = OP_REGISTER;
		else
			op = 3'($urandom_range(7, 5));
		rel = $urandom_range(1);
		if ($urandom_range(9) == 0)
			tv = $urandom;
		else if (rel)
			tv = $urandom_range(400);
		else
			tv = clock_now + $urandom_range(400) - 60;
		add_req(op, 4'($urandom_range(15)), tv, rel, $urandom_range(1), clock_now);
	endfunction

	task automatic drain();
		while (pending_reqs.size() > 0 || req_ch.valid || due_beats.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		errors = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		req_fire = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.operation = '0;
		req_ch.target_id = '0;
		req_ch.time_value = '0;
		req_ch.relative = 1'b0;
		req_ch.timer_kind = 1'b0;
		req_ch.now = '0;
		rsp_ch.ready = 1'b0;
		for (int i = 0; i < NTIMERS; i++) begin
			tmr_queued[i] = 1'b0;
			tmr_shot[i] = 1'b0;
		end
		arm_count = 0;
		next_id = 0;
		cmp_val = '0;
		defer_flag = 1'b0;
		clock_now = 32'hFFFF_FE00;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// unregistered ids, empty queue, unknown codes; then register every id
		add_req(OP_SET, 4'd3, 32'd50, 1'b0, 1'b0, 32'd0);
		add_req(OP_CLEAR, 4'd15, 32'd0, 1'b0, 1'b0, 32'd0);
		add_req(OP_EXPIRE, 4'd0, 32'd0, 1'b0, 1'b0, 32'hFFFF_FFFF);
		add_req(OP_SERVICE, 4'd0, 32'd0, 1'b0, 1'b0, 32'd0);
		add_req(3'd5, 4'd0, 32'd0, 1'b0, 1'b0, 32'd0);
		add_req(3'd7, 4'hF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
		for (int i = 0; i < NTIMERS; i++)
			add_req(OP_REGISTER, 4'd0, 32'd0, 1'b0, i % 3 == 1, 32'd0);
		// out of ids
		add_req(OP_REGISTER, 4'd0, 32'd0, 1'b0, 1'b1, 32'd0);
		drain();

		// past time fires at once; relative set across the wrap-around
		add_req(OP_SET, 4'd0, 32'd0, 1'b0, 1'b0, 32'd10);
		add_req(OP_SET, 4'd1, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'hFFFF_FF00);
		add_req(OP_SET, 4'd1, 32'd5, 1'b1, 1'b0, 32'd0);
		add_req(OP_SET, 4'd2, 32'd20, 1'b0, 1'b0, 32'd0);
		add_req(OP_SET, 4'd4, 32'd20, 1'b0, 1'b0, 32'd0);
		add_req(OP_CLEAR, 4'd3, 32'd0, 1'b0, 1'b0, 32'd0);
		add_req(OP_EXPIRE, 4'd0, 32'd0, 1'b0, 1'b0, 32'd30);
		add_req(OP_SERVICE, 4'd0, 32'd0, 1'b0, 1'b0, 32'd30);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; recv_idle_pct = 0; end
				1: begin send_idle_pct = 79; recv_idle_pct = 0; end
				2: begin send_idle_pct = 0; recv_idle_pct = 79; end
				default: begin send_idle_pct = 22; recv_idle_pct = 22; end
			endcase
			for (int n = 0; n < 33; n++)
				add_random_req();
			drain();
		end

		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
